// File: hdl/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// Field widths, result action codes and shared types for the voice channel
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vca_pkg;

	localparam int ID_W   = 16;
	localparam int LEN_W  = 32;
	localparam int TIME_W = 32;
	localparam int CHAN_W = 3;
	localparam int ACT_W  = 2;
	localparam int MASK_W = 8;

	typedef logic [ACT_W-1:0] action_t;

	localparam action_t ACT_FREE    = 2'd0;
	localparam action_t ACT_RETRIG  = 2'd1;
	localparam action_t ACT_STEAL   = 2'd2;

	typedef struct packed {
		logic done;
		logic free_found;
		logic match_found;
	} scan_flags_t;

endpackage

`default_nettype wire

// File: hdl/vca_req_if.sv
// ----------------------------------------------------------------------------
// vca_req_if
// Play request channel: valid/ready handshake with sound id, length and time.
// ----------------------------------------------------------------------------
`default_nettype none

interface vca_req_if
	import vca_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   sound_id;
	logic [LEN_W-1:0]  sound_length;
	logic [TIME_W-1:0] now_time;

	modport source (output valid, output sound_id, output sound_length, output now_time,
		input ready);
	modport sink (input valid, input sound_id, input sound_length, input now_time,
		output ready);
endinterface

`default_nettype wire

// File: hdl/vca_res_if.sv
// ----------------------------------------------------------------------------
// vca_res_if
// Allocation result channel: valid/ready handshake with channel, action and
// expiry mask.
// ----------------------------------------------------------------------------
`default_nettype none

interface vca_res_if
	import vca_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] channel;
	action_t           action;
	logic [MASK_W-1:0] expired_mask;

	modport source (output valid, output channel, output action, output expired_mask,
		input ready);
	modport sink (input valid, input channel, input action, input expired_mask,
		output ready);
endinterface

`default_nettype wire

// File: hdl/voice_channel_allocator_core.sv
// ----------------------------------------------------------------------------
// voice_channel_allocator_core
// Assigns a playback channel to each play request: expire, take free,
// retrigger same sound, or steal the channel with least remaining time.
// ----------------------------------------------------------------------------
// One request is handled at a time. The slot store has a single read port,
// so one channel entry is read per cycle. Two compare stages and an
// accumulate register follow the last read; the commit state then selects
// the channel combinationally, writes it back and loads the result register.
// The next request is taken in the cycle after write-back, while the earlier
// result may still wait in the output register. Write-back stalls while an
// earlier result waits unaccepted. Channel state needs no clearing pass after
// reset: only the busy bits are reset, and slot entries of idle channels never
// decide the result, since an idle channel is always taken as free first.
`default_nettype none

module voice_channel_allocator_core
	import vca_pkg::*;
#(
	parameter int CHANNELS  = 8,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	vca_req_if.sink   req,
	vca_res_if.source res
);

	localparam int CH_BITS = $clog2(CHANNELS);
	localparam int ENT_W   = ID_BITS + 2 * TIME_BITS;
	localparam logic [CH_BITS-1:0] LAST_IDX = CH_BITS'(CHANNELS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0]           state_q;
	logic [CH_BITS-1:0]   idx_q;
	logic [CHANNELS-1:0]  busy_q;
	logic [ID_BITS-1:0]   req_id_q;
	logic [TIME_BITS-1:0] req_len_q;
	logic [TIME_BITS-1:0] req_now_q;

	logic                 res_valid_q;
	logic [CHAN_W-1:0]    res_chan_q;
	action_t              res_act_q;
	logic [MASK_W-1:0]    res_mask_q;

	logic                 accept;
	logic                 commit;
	logic                 scan_rd;
	logic [ENT_W-1:0]     rd_data;
	scan_flags_t          flags;
	logic [CHANNELS-1:0]  exp_mask;
	logic [CH_BITS-1:0]   free_ch, match_ch, min_ch;
	logic [CH_BITS-1:0]   ch_sel;
	action_t              act_sel;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign scan_rd   = (state_q == ST_SCAN);
	assign commit    = (state_q == ST_COMMIT) && (!res_valid_q || res.ready);

	always_comb begin
		if (flags.free_found) begin
			ch_sel  = free_ch;
			act_sel = ACT_FREE;
		end else if (flags.match_found) begin
			ch_sel  = match_ch;
			act_sel = ACT_RETRIG;
		end else begin
			ch_sel  = min_ch;
			act_sel = ACT_STEAL;
		end
	end

	vca_slot_mem #(
		.CHANNELS (CHANNELS),
		.ENT_W    (ENT_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (ch_sel),
		.wr_data ({req_id_q, req_len_q, req_now_q}),
		.rd_en   (scan_rd),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	vca_scan #(
		.CHANNELS  (CHANNELS),
		.ID_BITS   (ID_BITS),
		.TIME_BITS (TIME_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.issue      (scan_rd),
		.issue_busy (busy_q[idx_q]),
		.issue_last (idx_q == LAST_IDX),
		.issue_idx  (idx_q),
		.rd_data    (rd_data),
		.req_id     (req_id_q),
		.req_len    (req_len_q),
		.req_now    (req_now_q),
		.flags      (flags),
		.exp_mask   (exp_mask),
		.free_ch    (free_ch),
		.match_ch   (match_ch),
		.min_ch     (min_ch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			busy_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (flags.done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				busy_q      <= (busy_q & ~exp_mask) | (CHANNELS'(1) << ch_sel);
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_id_q  <= ID_BITS'(req.sound_id);
			req_len_q <= TIME_BITS'(req.sound_length);
			req_now_q <= TIME_BITS'(req.now_time);
		end
		if (commit) begin
			res_chan_q <= CHAN_W'(ch_sel);
			res_act_q  <= act_sel;
			res_mask_q <= MASK_W'(exp_mask);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.channel      = res_chan_q;
	assign res.action       = res_act_q;
	assign res.expired_mask = res_mask_q;

`ifndef SYNTH
	a_commit_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> busy_q[$past(ch_sel)])
		else $error("chosen channel not marked busy after write-back");

	a_free_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (act_sel == ACT_FREE)) |-> (!busy_q[ch_sel] || exp_mask[ch_sel]))
		else $error("free channel taken while still busy");

	a_expired_were_busy: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> ((exp_mask & ~busy_q) == '0))
		else $error("idle channel reported as expired");
`endif

endmodule

`default_nettype wire

// File: hdl/vca_slot_mem.sv
// ----------------------------------------------------------------------------
// vca_slot_mem
// Channel slot store: sound id, length and start time per channel, one write
// port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_slot_mem
	import vca_pkg::*;
#(
	parameter int CHANNELS = 8,
	parameter int ENT_W    = 80
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [$clog2(CHANNELS)-1:0] wr_addr,
	input  wire logic [ENT_W-1:0]            wr_data,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(CHANNELS)-1:0] rd_addr,
	output logic      [ENT_W-1:0]            rd_data
);

	logic [ENT_W-1:0] mem [CHANNELS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/vca_scan.sv
// ----------------------------------------------------------------------------
// vca_scan
// Per-channel scan pipeline: expiry test, same-sound match and least
// remaining time, accumulated over one pass of slot reads.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_scan
	import vca_pkg::*;
#(
	parameter int CHANNELS  = 8,
	parameter int ID_BITS   = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           clear,
	input  wire logic                           issue,
	input  wire logic                           issue_busy,
	input  wire logic                           issue_last,
	input  wire logic [$clog2(CHANNELS)-1:0]    issue_idx,
	input  wire logic [ID_BITS+2*TIME_BITS-1:0] rd_data,
	input  wire logic [ID_BITS-1:0]             req_id,
	input  wire logic [TIME_BITS-1:0]           req_len,
	input  wire logic [TIME_BITS-1:0]           req_now,
	output scan_flags_t                         flags,
	output logic      [CHANNELS-1:0]            exp_mask,
	output logic      [$clog2(CHANNELS)-1:0]    free_ch,
	output logic      [$clog2(CHANNELS)-1:0]    match_ch,
	output logic      [$clog2(CHANNELS)-1:0]    min_ch
);

	localparam int CH_BITS = $clog2(CHANNELS);
	localparam int ENT_W   = ID_BITS + 2 * TIME_BITS;

	logic [ID_BITS-1:0]   ent_sound;
	logic [TIME_BITS-1:0] ent_length;
	logic [TIME_BITS-1:0] ent_start;

	logic               valid_s1, valid_s2, valid_s3;
	logic               busy_s1, busy_s2;
	logic               last_s1, last_s2, last_s3;
	logic [CH_BITS-1:0] idx_s1, idx_s2, idx_s3;

	logic [TIME_BITS-1:0] elapsed_s2, length_s2;
	logic                 match_s2;

	logic                 expired_s3, free_s3, match_s3;
	logic [TIME_BITS-1:0] rem_s3;

	logic                 free_found_q, match_found_q, done_q;
	logic [TIME_BITS-1:0] best_q;

	assign ent_sound  = rd_data[ENT_W-1 -: ID_BITS];
	assign ent_length = rd_data[2*TIME_BITS-1:TIME_BITS];
	assign ent_start  = rd_data[TIME_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		busy_s1    <= issue_busy;
		last_s1    <= issue_last;
		idx_s1     <= issue_idx;

		elapsed_s2 <= req_now - ent_start;
		length_s2  <= ent_length;
		match_s2   <= (ent_sound == req_id) && (ent_length == req_len);
		busy_s2    <= busy_s1;
		last_s2    <= last_s1;
		idx_s2     <= idx_s1;

		expired_s3 <= busy_s2 && (elapsed_s2 > length_s2);
		free_s3    <= !busy_s2 || (elapsed_s2 > length_s2);
		rem_s3     <= length_s2 - elapsed_s2;
		match_s3   <= match_s2;
		last_s3    <= last_s2;
		idx_s3     <= idx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			done_q        <= 1'b0;
			exp_mask      <= '0;
			free_ch       <= '0;
			match_ch      <= '0;
			min_ch        <= '0;
			best_q        <= '0;
		end else if (clear) begin
			free_found_q  <= 1'b0;
			match_found_q <= 1'b0;
			done_q        <= 1'b0;
			exp_mask      <= '0;
		end else begin
			done_q <= valid_s3 && last_s3;
			if (valid_s3) begin
				if (expired_s3) begin
					exp_mask[idx_s3] <= 1'b1;
				end
				if (free_s3 && !free_found_q) begin
					free_found_q <= 1'b1;
					free_ch      <= idx_s3;
				end
				if (match_s3 && !match_found_q) begin
					match_found_q <= 1'b1;
					match_ch      <= idx_s3;
				end
				if ((idx_s3 == '0) || ($signed(rem_s3) < $signed(best_q))) begin
					best_q <= rem_s3;
					min_ch <= idx_s3;
				end
			end
		end
	end

	assign flags.done        = done_q;
	assign flags.free_found  = free_found_q;
	assign flags.match_found = match_found_q;

endmodule

`default_nettype wire

// File: tb/vca_alloc_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vca_alloc_monitor
// Watches the request and result channels of the voice channel allocator,
// tracks channel occupancy on its own, works out the allocation each accepted
// request should get and compares every result against it in order.
// ----------------------------------------------------------------------------

module vca_alloc_monitor
	import vca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	vca_req_if   req,
	vca_res_if   res,
	output int   errors,
	output int   outstanding,
	output int   free_takes,
	output int   retriggers,
	output int   steals,
	output int   expiries
);

	localparam int N_CHAN     = 8;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		action_t           action;
		logic [MASK_W-1:0] expired_mask;
	} alloc_t;

	logic              chan_busy  [N_CHAN];
	logic [ID_W-1:0]   chan_id    [N_CHAN];
	logic [TIME_W-1:0] chan_len   [N_CHAN];
	logic [TIME_W-1:0] chan_start [N_CHAN];

	alloc_t pending_allocs[$];

	int mismatch_count = 0;
	int waiting        = 0;
	int n_free         = 0;
	int n_retrig       = 0;
	int n_steal        = 0;
	int n_expired      = 0;

	assign errors      = mismatch_count;
	assign outstanding = waiting;
	assign free_takes  = n_free;
	assign retriggers  = n_retrig;
	assign steals      = n_steal;
	assign expiries    = n_expired;

	task automatic report_mismatch(input string msg);
		$display("[%0t] allocation check: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic alloc_t allocate(input logic [ID_W-1:0] id,
			input logic [LEN_W-1:0] len, input logic [TIME_W-1:0] now);
		alloc_t                   r;
		logic                     found;
		logic [TIME_W-1:0]        elapsed;
		logic signed [TIME_W-1:0] left;
		logic signed [TIME_W-1:0] least;
		int                       ch;
		r     = '0;
		found = 1'b0;
		ch    = 0;
		for (int i = 0; i < N_CHAN; i++) begin
			elapsed = now - chan_start[i];
			if (chan_busy[i] && elapsed > chan_len[i]) begin
				chan_busy[i]      = 1'b0;
				chan_start[i]     = '0;
				r.expired_mask[i] = 1'b1;
			end
		end
		for (int i = 0; i < N_CHAN; i++) begin
			if (!found && !chan_busy[i]) begin
				ch       = i;
				r.action = ACT_FREE;
				found    = 1'b1;
			end
		end
		for (int i = 0; i < N_CHAN; i++) begin
			if (!found && chan_id[i] == id && chan_len[i] == len[TIME_W-1:0]) begin
				ch       = i;
				r.action = ACT_RETRIG;
				found    = 1'b1;
			end
		end
		if (!found) begin
			r.action = ACT_STEAL;
			ch       = 0;
			least    = $signed(chan_len[0] - (now - chan_start[0]));
			for (int i = 1; i < N_CHAN; i++) begin
				left = $signed(chan_len[i] - (now - chan_start[i]));
				if (left < least) begin
					least = left;
					ch    = i;
				end
			end
		end
		r.channel      = CHAN_W'(ch);
		chan_busy[ch]  = 1'b1;
		chan_id[ch]    = id;
		chan_len[ch]   = len[TIME_W-1:0];
		chan_start[ch] = now;
		return r;
	endfunction

	task automatic check_result();
		alloc_t want;
		if (pending_allocs.size() == 0) begin
			report_mismatch($sformatf("unexpected result: channel %0d action %0d expired %02h",
				res.channel, res.action, res.expired_mask));
			return;
		end
		want = pending_allocs.pop_front();
		if (res.channel !== want.channel)
			report_mismatch($sformatf("channel: got %0d, want %0d", res.channel,
				want.channel));
		if (res.action !== want.action)
			report_mismatch($sformatf("action on channel %0d: got %0d, want %0d",
				want.channel, res.action, want.action));
		if (res.expired_mask !== want.expired_mask)
			report_mismatch($sformatf("expired mask: got %02h, want %02h",
				res.expired_mask, want.expired_mask));
	endtask

	always @(posedge clk) begin
		alloc_t next;
		if (!arst_n) begin
			for (int i = 0; i < N_CHAN; i++) begin
				chan_busy[i]  = 1'b0;
				chan_id[i]    = '0;
				chan_len[i]   = '0;
				chan_start[i] = '0;
			end
			pending_allocs.delete();
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (req.valid && req.ready) begin
				next = allocate(req.sound_id, req.sound_length, req.now_time);
				case (next.action)
					ACT_FREE:   n_free++;
					ACT_RETRIG: n_retrig++;
					default:    n_steal++;
				endcase
				n_expired += $countones(next.expired_mask);
				pending_allocs.push_back(next);
			end
		end
		waiting = pending_allocs.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives play requests into voice_channel_allocator_core: a directed opening
// through free takes, retriggers, steals, expiry and time wrap, then random
// requests from small id and length pools with random time steps, mixed with
// full-range noise. Both sides idle at random and the result side holds off
// for long stretches; an allocation monitor checks every result.
// ----------------------------------------------------------------------------

module tb;
	import vca_pkg::*;

	localparam int RANDOM_REQUESTS = 1800;
	localparam int DRAIN_CYCLES    = 40;
	localparam int HOLD_CYCLES     = 300;
	localparam int CYCLE_LIMIT     = 400000;

	logic clk;
	logic arst_n;

	vca_req_if req_ch();
	vca_res_if res_ch();

	int   errors;
	int   outstanding;
	int   free_takes;
	int   retriggers;
	int   steals;
	int   expiries;
	int   requests_sent = 0;
	int   cycle_count   = 0;
	logic rx_hold;
	logic tx_steady     = 1'b0;

	voice_channel_allocator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	vca_alloc_monitor alloc_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.res         (res_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.free_takes  (free_takes),
		.retriggers  (retriggers),
		.steals      (steals),
		.expiries    (expiries)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("voice_channel_allocator_core: mismatch");
			$finish;
		end
	end

	task automatic send_req(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input logic [TIME_W-1:0] now);
		int gap;
		if (requests_sent % 80 == 0)
			tx_steady = ($urandom_range(0, 3) == 0);
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.sound_id     <= id;
		req_ch.sound_length <= len;
		req_ch.now_time     <= now;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
	endtask

	initial begin
		int   rx_wait;
		int   rx_done;
		logic rx_steady;
		rx_wait   = 0;
		rx_done   = 0;
		rx_steady = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				rx_done++;
				if (rx_done % 100 == 0)
					rx_steady = ($urandom_range(0, 3) == 0);
				rx_wait = rx_steady ? 0 : $urandom_range(0, 11);
			end
			if (rx_hold || rx_wait > 0) begin
				res_ch.ready <= 1'b0;
				if (!rx_hold)
					rx_wait--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		rx_hold <= 1'b0;
		for (int h = 1; h <= 2; h++) begin
			wait (requests_sent >= h * 600);
			@(posedge clk);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		int                pick;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] tick;
		tick = '0;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.sound_id     <= '0;
		req_ch.sound_length <= '0;
		req_ch.now_time     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(16'h0000, 32'h0000_0000, 32'h0000_0000);
		send_req(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		for (int k = 1; k <= 8; k++)
			send_req(ID_W'(k), 32'd1000, 32'd10);
		send_req(16'h0003, 32'd1000, 32'd20);
		send_req(16'hABCD, 32'd5, 32'd30);
		send_req(16'h0002, 32'd1000, 32'd2000);
		send_req(16'h0001, 32'h7FFF_FFFF, 32'h8000_0000);
		send_req(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send_req(16'h0007, 32'h0000_0020, 32'hFFFF_FFF8);
		send_req(16'h0007, 32'h0000_0020, 32'h0000_0010);
		send_req(16'h0007, 32'h0000_0020, 32'h0000_0019);
		send_req(16'h8000, 32'h8000_0000, 32'h0000_0019);
		send_req(16'h8000, 32'h8000_0000, 32'h0000_0019);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				id  = ID_W'($urandom);
				len = $urandom;
				now = $urandom;
				if (pick < 7)
					tick = now;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					tick += $urandom_range(0, 3);
				else if (pick < 95)
					tick += $urandom_range(0, 300);
				else
					tick += $urandom;
				case ($urandom_range(0, 5))
					0:       id = 16'h0000;
					1:       id = 16'h0001;
					2:       id = 16'h0002;
					3:       id = 16'h8000;
					4:       id = 16'hFFFF;
					default: id = 16'h5A5A;
				endcase
				case ($urandom_range(0, 11))
					0:       len = 32'd0;
					1:       len = 32'd3;
					2, 3:    len = 32'd40;
					4, 5:    len = 32'd250;
					6, 7:    len = 32'd1000;
					8:       len = 32'h7FFF_FFFF;
					9:       len = 32'h8000_0000;
					10:      len = 32'hFFFF_FFFF;
					default: len = 32'd120;
				endcase
				now = tick;
			end
			send_req(id, len, now);
		end
		req_ch.valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d free takes, %0d retriggers, %0d steals",
			requests_sent, free_takes, retriggers, steals);
		$display("channels freed by expiry: %0d, long result-side hold-offs: 2", expiries);
		if (errors == 0)
			$display("voice_channel_allocator_core: match");
		else
			$display("voice_channel_allocator_core: mismatch");
		$finish;
	end

endmodule
